// ----- hdl/pwsm_pkg.sv -----
// Package for the perspective warp source mapper: field widths, register
// indexes and the payload carried along the divider cell chain.
// No dependencies.
package pwsm_pkg;

	localparam int COEF_W  = 48;          // signed Q20.28 coefficient
	localparam int PIX_W   = 12;          // pixel coordinate
	localparam int PROD_W  = COEF_W + PIX_W + 1;
	localparam int SUM_W   = 64;          // numerator / denominator
	localparam int MAG_W   = SUM_W - 1;   // magnitude of a sum
	localparam int QUO_W   = PIX_W + 1;   // quotient bits, top bit flags >= 4096
	localparam int REM_W   = MAG_W + QUO_W;
	localparam int NUM_COEFS = 8;
	localparam int IDX_W   = 3;
	localparam int ADDR_W  = 6;
	localparam int DATA_W  = 64;
	localparam logic signed [SUM_W-1:0] Q_ONE = SUM_W'(64'sd268435456);

	typedef enum logic [IDX_W-1:0] {
		REG_XX = 3'd0,
		REG_XY = 3'd1,
		REG_XC = 3'd2,
		REG_YX = 3'd3,
		REG_YY = 3'd4,
		REG_YC = 3'd5,
		REG_WX = 3'd6,
		REG_WY = 3'd7
	} coef_idx_t;

	// Payload handed from one divider cell to the next.
	typedef struct packed {
		logic [PIX_W-1:0] dest_x;
		logic [PIX_W-1:0] dest_y;
		logic             neg_x;
		logic             neg_y;
		logic             dzero;
		logic [MAG_W-1:0] md;
		logic [REM_W-1:0] rem_x;
		logic [REM_W-1:0] rem_y;
		logic [QUO_W-1:0] qx;
		logic [QUO_W-1:0] qy;
	} div_lane_t;

endpackage

// ----- hdl/pwsm_div_cell.sv -----
// One cell of the restoring divider chain: settles one quotient bit of
// both the x and y lanes. Depends on pwsm_pkg.
module pwsm_div_cell import pwsm_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_in,
	input  div_lane_t lane_in,
	output logic      valid_out,
	output div_lane_t lane_out
);

	logic      valid_s1;
	div_lane_t lane_s1;
	div_lane_t lane_nxt;
	logic [REM_W-1:0] dsh;
	logic tx;
	logic ty;

	always_comb begin
		lane_nxt = lane_in;
		dsh = REM_W'(lane_in.md) << SHIFT;
		tx = (lane_in.rem_x >= dsh);
		ty = (lane_in.rem_y >= dsh);
		if (tx) begin
			lane_nxt.rem_x = lane_in.rem_x - dsh;
		end
		if (ty) begin
			lane_nxt.rem_y = lane_in.rem_y - dsh;
		end
		lane_nxt.qx = lane_in.qx | (QUO_W'(tx) << SHIFT);
		lane_nxt.qy = lane_in.qy | (QUO_W'(ty) << SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		lane_s1 <= lane_nxt;
	end

	assign valid_out = valid_s1;
	assign lane_out  = lane_s1;

endmodule

// ----- hdl/perspective_warp_source_mapper.sv -----
// Top level of the perspective warp source mapper: coefficient registers,
// product and sum stages, the divider cell chain and the result register.
// Depends on pwsm_pkg and pwsm_div_cell.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  input    | start & !busy        | dest_x, dest_y
//  result   | done (one cycle)     | out_dest_x, out_dest_y, src_x, src_y,
//           |                      | in_range
//  config   | psel&penable&pwrite  | paddr[5:3] register, pwdata[47:0]
//
// One transfer is taken every cycle; busy is always low. Sixteen registers
// lie between input and result: one product stage, one sum stage, thirteen
// divider cells (one quotient bit each) and the result register. The product
// stage loads at the input's transfer edge, and done is registered together
// with the result outputs.
// Reset clears the valid bits of the pipeline and loads the identity
// homography. The receiver cannot stall, so nothing is held back.
module perspective_warp_source_mapper import pwsm_pkg::*; #(
	parameter int SRC_WIDTH  = 1024,
	parameter int SRC_HEIGHT = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [PIX_W-1:0]  dest_x,
	input  logic [PIX_W-1:0]  dest_y,
	output logic              done,
	output logic [PIX_W-1:0]  out_dest_x,
	output logic [PIX_W-1:0]  out_dest_y,
	output logic [PIX_W-1:0]  src_x,
	output logic [PIX_W-1:0]  src_y,
	output logic              in_range,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam logic [QUO_W-1:0] LIM_X = QUO_W'(SRC_WIDTH);
	localparam logic [QUO_W-1:0] LIM_Y = QUO_W'(SRC_HEIGHT);
	localparam int NCELL = QUO_W;

	// Coefficient registers
	logic signed [COEF_W-1:0] coef_q [NUM_COEFS];
	coef_idx_t widx;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign widx   = coef_idx_t'(paddr[ADDR_W-1:ADDR_W-IDX_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				if (i == int'(REG_XX) || i == int'(REG_YY)) begin
					coef_q[i] <= COEF_W'(48'sd268435456);
				end else begin
					coef_q[i] <= '0;
				end
			end
		end else if (psel && penable && pwrite && pready) begin
			coef_q[widx] <= pwdata[COEF_W-1:0];
		end
	end

	assign prdata = DATA_W'(coef_q[widx]);

	// Stage 1: six products
	logic                     valid_s1;
	logic [PIX_W-1:0]         dx_s1, dy_s1;
	logic signed [PROD_W-1:0] pxx_s1, pxy_s1, pyx_s1, pyy_s1, pwx_s1, pwy_s1;
	logic signed [COEF_W-1:0] cxc_s1, cyc_s1;
	logic signed [PIX_W:0]    sx_in, sy_in;

	assign sx_in = $signed({1'b0, dest_x});
	assign sy_in = $signed({1'b0, dest_y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= dest_x;
		dy_s1  <= dest_y;
		pxx_s1 <= PROD_W'(coef_q[REG_XX] * sx_in);
		pxy_s1 <= PROD_W'(coef_q[REG_XY] * sy_in);
		pyx_s1 <= PROD_W'(coef_q[REG_YX] * sx_in);
		pyy_s1 <= PROD_W'(coef_q[REG_YY] * sy_in);
		pwx_s1 <= PROD_W'(coef_q[REG_WX] * sx_in);
		pwy_s1 <= PROD_W'(coef_q[REG_WY] * sy_in);
		cxc_s1 <= coef_q[REG_XC];
		cyc_s1 <= coef_q[REG_YC];
	end

	// Stage 2: sums, split into sign and magnitude
	logic signed [SUM_W-1:0] nx, ny, dd;
	logic [SUM_W-1:0] mnx, mny, mdd;
	logic      valid_s2;
	div_lane_t lane_s2;

	always_comb begin
		nx  = SUM_W'(pxx_s1) + SUM_W'(pxy_s1) + SUM_W'(cxc_s1);
		ny  = SUM_W'(pyx_s1) + SUM_W'(pyy_s1) + SUM_W'(cyc_s1);
		dd  = SUM_W'(pwx_s1) + SUM_W'(pwy_s1) + Q_ONE;
		mnx = nx[SUM_W-1] ? -nx : nx;
		mny = ny[SUM_W-1] ? -ny : ny;
		mdd = dd[SUM_W-1] ? -dd : dd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		lane_s2.dest_x <= dx_s1;
		lane_s2.dest_y <= dy_s1;
		lane_s2.neg_x  <= nx[SUM_W-1] ^ dd[SUM_W-1];
		lane_s2.neg_y  <= ny[SUM_W-1] ^ dd[SUM_W-1];
		lane_s2.dzero  <= (dd == '0);
		lane_s2.md     <= mdd[MAG_W-1:0];
		lane_s2.rem_x  <= REM_W'(mnx[MAG_W-1:0]);
		lane_s2.rem_y  <= REM_W'(mny[MAG_W-1:0]);
		lane_s2.qx     <= '0;
		lane_s2.qy     <= '0;
	end

	// Divider chain: the first cell settles the top bit (quotient >= 4096),
	// each following cell one bit lower.
	logic      cv [NCELL+1];
	div_lane_t cl [NCELL+1];

	assign cv[0] = valid_s2;
	assign cl[0] = lane_s2;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		pwsm_div_cell #(.SHIFT(NCELL - 1 - k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (cv[k]),
			.lane_in   (cl[k]),
			.valid_out (cv[k+1]),
			.lane_out  (cl[k+1])
		);
	end

	// Result register: a zero quotient is always inside; otherwise drop
	// negative or too large quotients, and drop everything on a zero
	// denominator.
	div_lane_t fin;
	logic okx, oky, ok;

	assign fin = cl[NCELL];

	always_comb begin
		okx = (fin.qx == '0) || (!fin.neg_x && (fin.qx < LIM_X));
		oky = (fin.qy == '0) || (!fin.neg_y && (fin.qy < LIM_Y));
		ok  = !fin.dzero && okx && oky;
	end

	logic             done_q;
	logic [PIX_W-1:0] odx_q, ody_q, srcx_q, srcy_q;
	logic             inr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cv[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		odx_q  <= fin.dest_x;
		ody_q  <= fin.dest_y;
		srcx_q <= ok ? fin.qx[PIX_W-1:0] : '0;
		srcy_q <= ok ? fin.qy[PIX_W-1:0] : '0;
		inr_q  <= ok;
	end

	assign done       = done_q;
	assign out_dest_x = odx_q;
	assign out_dest_y = ody_q;
	assign src_x      = srcx_q;
	assign src_y      = srcy_q;
	assign in_range   = inr_q;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for perspective_warp_source_mapper: maps random and
// directed destination pixels through several homographies and checks each result.
// Depends on pwsm_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
	import pwsm_pkg::*;

	localparam int SRC_W_PIX = 1024;
	localparam int SRC_H_PIX = 1024;
	localparam longint ONE_Q28 = 64'sd268435456;

	typedef struct {
		logic [PIX_W-1:0] dx;
		logic [PIX_W-1:0] dy;
	} pixel_t;

	typedef struct {
		logic [PIX_W-1:0] dx;
		logic [PIX_W-1:0] dy;
		logic [PIX_W-1:0] sx;
		logic [PIX_W-1:0] sy;
		logic             hit;
	} mapping_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [PIX_W-1:0] dest_x = '0;
	logic [PIX_W-1:0] dest_y = '0;
	logic done;
	logic [PIX_W-1:0] out_dest_x, out_dest_y, src_x, src_y;
	logic in_range;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// Predictor's own copy of the homography
	longint homog [NUM_COEFS];

	pixel_t   pixel_q [$];
	mapping_t mapping_q [$];
	int       fail_count = 0;
	int       quiet_gap = 0;   // idling is suppressed while non-zero
	bit       phase_on = 1'b0;
	bit       cfg_req = 1'b0;
	bit       cfg_ack = 1'b0;
	coef_idx_t cfg_idx;
	logic [DATA_W-1:0] cfg_val;

	perspective_warp_source_mapper #(
		.SRC_WIDTH (SRC_W_PIX),
		.SRC_HEIGHT(SRC_H_PIX)
	) DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Truncating division, sign applied afterwards; small negatives fall to 0
	function automatic bit map_axis(longint n, longint d, int lim, output logic [PIX_W-1:0] q);
		bit     neg;
		longint mn, md, mq;
		neg = (n < 0) != (d < 0);
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		mq = mn / md;
		q = '0;
		if (mq == 0) return 1'b1;
		if (neg || mq >= lim) return 1'b0;
		q = mq[PIX_W-1:0];
		return 1'b1;
	endfunction

	function automatic mapping_t warp_pixel(pixel_t p);
		mapping_t m;
		longint x, y, nx, ny, d;
		bit okx, oky;
		x = p.dx;
		y = p.dy;
		nx = homog[REG_XX]*x + homog[REG_XY]*y + homog[REG_XC];
		ny = homog[REG_YX]*x + homog[REG_YY]*y + homog[REG_YC];
		d  = homog[REG_WX]*x + homog[REG_WY]*y + ONE_Q28;
		m.dx = p.dx;
		m.dy = p.dy;
		m.sx = '0;
		m.sy = '0;
		m.hit = 1'b0;
		if (d != 0) begin
			okx = map_axis(nx, d, SRC_W_PIX, m.sx);
			oky = map_axis(ny, d, SRC_H_PIX, m.sy);
			m.hit = okx && oky;
		end
		if (!m.hit) begin
			m.sx = '0;
			m.sy = '0;
		end
		return m;
	endfunction

	// Driver: pixel transfers while a phase runs, otherwise register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				mapping_q.insert(mapping_q.size(), warp_pixel(pixel_q.pop_front()));
			end
			if (psel && penable) begin
				psel <= 1'b0;
				penable <= 1'b0;
				pwrite <= 1'b0;
				cfg_ack <= 1'b1;
			end else if (psel) begin
				penable <= 1'b1;
			end else if (cfg_req && !cfg_ack) begin
				psel <= 1'b1;
				pwrite <= 1'b1;
				paddr <= ADDR_W'(cfg_idx * 8);
				pwdata <= cfg_val;
			end else if (!cfg_req) begin
				cfg_ack <= 1'b0;
			end
			if (quiet_gap > 0) quiet_gap <= quiet_gap - 1;
			// Any transferred item is popped already, so the head is the next to send
			if (phase_on && (pixel_q.size() > 0)
				&& (quiet_gap > 0 || $urandom_range(99) >= 19)) begin
				start <= 1'b1;
				dest_x <= pixel_q[0].dx;
				dest_y <= pixel_q[0].dy;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		mapping_t e;
		if (arst_n && done) begin
			if (mapping_q.size() == 0) begin
				$error("unexpected result dest=(%0d,%0d)", out_dest_x, out_dest_y);
				fail_count++;
			end else begin
				e = mapping_q.pop_front();
				if (out_dest_x !== e.dx) begin
					$error("out_dest_x exp %0d got %0d", e.dx, out_dest_x); fail_count++;
				end
				if (out_dest_y !== e.dy) begin
					$error("out_dest_y exp %0d got %0d", e.dy, out_dest_y); fail_count++;
				end
				if (src_x !== e.sx) begin
					$error("src_x exp %0d got %0d", e.sx, src_x); fail_count++;
				end
				if (src_y !== e.sy) begin
					$error("src_y exp %0d got %0d", e.sy, src_y); fail_count++;
				end
				if (in_range !== e.hit) begin
					$error("in_range exp %0d got %0d", e.hit, in_range); fail_count++;
				end
			end
		end
	end

	task automatic write_coef(coef_idx_t idx, longint v);
		cfg_idx = idx;
		cfg_val = DATA_W'(v);
		cfg_req = 1'b1;
		@(posedge clk iff cfg_ack);
		cfg_req = 1'b0;
		@(posedge clk iff !cfg_ack);
		homog[idx] = longint'(signed'(v[COEF_W-1:0]));
	endtask

	task automatic add_pixel(int x, int y);
		pixel_t p;
		p.dx = PIX_W'(x);
		p.dy = PIX_W'(y);
		pixel_q.insert(pixel_q.size(), p);
	endtask

	// Run queued pixels, then drain the pipeline before the next write
	task automatic run_phase();
		phase_on = 1'b1;
		@(posedge clk iff (pixel_q.size() == 0));
		phase_on = 1'b0;
		@(posedge clk iff (mapping_q.size() == 0));
		repeat (20) @(posedge clk);
	endtask

	function automatic longint rand_coef(int mode);
		longint v;
		case (mode)
			0: v = {$urandom, $urandom};                          // any 48-bit
			1: v = longint'($urandom_range(2*ONE_Q28)) - ONE_Q28;  // modest gain
			default: v = longint'($urandom_range(2*ONE_Q28/64)) - ONE_Q28/64;
		endcase
		return v;
	endfunction

	initial begin
		homog = '{ONE_Q28, 0, 0, 0, ONE_Q28, 0, 0, 0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Identity: extremes of the pixel fields, edge of the frame
		add_pixel(0, 0); add_pixel(4095, 4095); add_pixel(1023, 1023);
		add_pixel(1024, 5); add_pixel(5, 1024); add_pixel(2730, 1365);
		run_phase();

		// Negative translation: small negative quotients truncate to zero
		write_coef(REG_XC, -ONE_Q28/2);
		write_coef(REG_YC, -3*ONE_Q28);
		add_pixel(0, 0); add_pixel(0, 3); add_pixel(1, 4); add_pixel(0, 2);
		run_phase();

		// Denominator zero at dest_x = 256 (wx = -1/256)
		write_coef(REG_XC, 0);
		write_coef(REG_YC, 0);
		write_coef(REG_WX, -ONE_Q28/256);
		add_pixel(256, 0); add_pixel(257, 9); add_pixel(255, 9); add_pixel(300, 0);
		run_phase();

		// Register extremes, including excess bits above 48
		write_coef(REG_XY, 64'sh7FFF_FFFF_FFFF);
		write_coef(REG_YX, 64'shFFFF_8000_0000_0000);
		write_coef(REG_WY, 64'sh7FFF_FFFF_FFFF);
		write_coef(REG_WX, 0);
		add_pixel(0, 0); add_pixel(4095, 4095); add_pixel(4095, 0); add_pixel(0, 4095);
		run_phase();

		// Random phases: new homography each, then random pixels
		for (int ph = 0; ph < 14; ph++) begin
			int mode;
			mode = $urandom_range(2);
			for (int r = 0; r < NUM_COEFS; r++) begin
				longint v;
				if (r == REG_WX || r == REG_WY) v = (mode == 0) ? rand_coef(0) : rand_coef(2);
				else if (r == REG_XC || r == REG_YC) v = rand_coef(0) >>> $urandom_range(20);
				else v = rand_coef(mode == 0 ? 0 : 1);
				write_coef(coef_idx_t'(r), v);
			end
			if (ph == 3) quiet_gap = 200;
			for (int k = 0; k < 75; k++) begin
				if ($urandom_range(3) == 0) add_pixel($urandom_range(4095), $urandom_range(4095));
				else add_pixel($urandom_range(1100), $urandom_range(1100));
			end
			run_phase();
		end

		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
